### design/btdm_pkg.sv
// Shared types, constants and helper functions for the tag dictionary match block.
// No dependencies; the front end, back end and top-level files import this package.
package btdm_pkg;

   localparam int POSITIONS = 32;
   localparam int ALPHABET  = 128;
   localparam int TAG_SLOTS = 64;

   localparam int OP_W    = 2;
   localparam int TAG_W   = 6;
   localparam int POS_W   = 5;
   localparam int CHAR_W  = 7;
   localparam int MASK_W  = 64;
   localparam int HALF_W  = MASK_W / 2;
   localparam int HALF_IW = $clog2(HALF_W);

   localparam int PIDX_W    = $clog2(POSITIONS);
   localparam int LPOS_W    = $clog2(POSITIONS + 1);
   localparam int ADDR_W    = PIDX_W + CHAR_W;
   localparam int TBL_DEPTH = POSITIONS * ALPHABET;

   localparam int FQ_DEPTH = 4;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

   localparam int OQ_DEPTH = 2;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_CHAR  = 2'd2;
   localparam logic [OP_W-1:0] OP_END   = 2'd3;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 7'd32;
   localparam logic [MASK_W-1:0] ALL_ONES   = {MASK_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [PIDX_W-1:0] pidx;
      logic [CHAR_W-1:0] ch;
      logic              in_range;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic             found;
      logic [TAG_W-1:0] tag_number;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic push;
   } back_status_type;

   function automatic logic [HALF_IW-1:0] top_bit(input logic [HALF_W-1:0] v);
      logic [HALF_IW-1:0] n;
      n = '0;
      for (int i = 0; i < HALF_W; i++) begin
         if (v[i]) begin
            n = HALF_IW'(i);
         end
      end
      return n;
   endfunction

endpackage

### design/bit_parallel_tag_dictionary_match.sv
// Result path: an end item's result passes the front queue, the issue and data states and the
// result queue before it can be popped; an overrun string skips the data state and its read.
// Execution: clear, ignored and overrunning items need only the issue state; in-range mark,
// character and end items also pass the data state, reading the table RAM before using it.
// Reset: a pass clears all 4096 table entries; requests fill the four-deep queue meanwhile.
// Top level: front end, back end and the two-entry result queue. Depends on btdm_pkg.
module bit_parallel_tag_dictionary_match (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [btdm_pkg::OP_W-1:0]     req_operation,
   input  logic [btdm_pkg::TAG_W-1:0]    req_tag_number_in,
   input  logic [btdm_pkg::POS_W-1:0]    req_char_position,
   input  logic [btdm_pkg::CHAR_W-1:0]   req_character,
   output logic                          empty,
   input  logic                          pop,
   output logic                          rsp_found,
   output logic [btdm_pkg::TAG_W-1:0]    rsp_tag_number
);
   import btdm_pkg::*;

   head_type            head;
   logic                take;
   back_status_type     status;
   result_type          result;
   logic                out_space;
   logic                do_pop;

   result_type          oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;

   btdm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_operation     (req_operation),
      .req_tag_number_in (req_tag_number_in),
      .req_char_position (req_char_position),
      .req_character     (req_character),
      .head              (head),
      .take              (take)
   );

   btdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .take      (take),
      .out_space (out_space),
      .status    (status),
      .result    (result)
   );

   assign out_space      = oq_cnt_ff < OQ_CNT_W'(OQ_DEPTH);
   assign empty          = oq_cnt_ff == '0;
   assign do_pop         = pop && !empty;
   assign rsp_found      = oq_ff[oq_rd_ff].found;
   assign rsp_tag_number = oq_ff[oq_rd_ff].tag_number;

   always_comb begin
      oq_wr_in  = status.push ? oq_wr_ff + 1'b1 : oq_wr_ff;
      oq_rd_in  = do_pop ? oq_rd_ff + 1'b1 : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (status.push && !do_pop) begin
         oq_cnt_in = oq_cnt_ff + 1'b1;
      end else if (do_pop && !status.push) begin
         oq_cnt_in = oq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.push) begin
         oq_ff[oq_wr_ff] <= result;
      end
   end

   // No request may be executed while the table is still being cleared.
   assert property (@(posedge clock) disable iff (reset) status.clearing |-> !take)
      else $error("request taken during table clearing pass");

   // A result must never be written into a full result queue.
   assert property (@(posedge clock) disable iff (reset)
      (status.push && oq_cnt_ff == OQ_CNT_W'(OQ_DEPTH)) |-> do_pop)
      else $error("result written into full result queue");

   // A pop transfer without a new result shortens the queue by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (do_pop && !status.push) |=> oq_cnt_ff == $past(oq_cnt_ff) - 1'b1)
      else $error("result queue count wrong after pop transfer");

endmodule

### design/btdm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module btdm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/btdm_front.sv
// Front end: accepts request transfers, classifies them and holds them in a short queue.
// Depends on btdm_pkg.
module btdm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [btdm_pkg::OP_W-1:0]     req_operation,
   input  logic [btdm_pkg::TAG_W-1:0]    req_tag_number_in,
   input  logic [btdm_pkg::POS_W-1:0]    req_char_position,
   input  logic [btdm_pkg::CHAR_W-1:0]   req_character,
   output btdm_pkg::head_type            head,
   input  logic                          take
);
   import btdm_pkg::*;

   item_type              mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   item_type              new_item;
   logic                  pos_ok;
   logic                  tag_ok;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      pos_ok = int'(req_char_position) < POSITIONS;
      tag_ok = int'(req_tag_number_in) < TAG_SLOTS;
      new_item.op   = req_operation;
      new_item.tag  = req_tag_number_in;
      new_item.pidx = PIDX_W'(req_char_position);
      new_item.ch   = req_character;
      unique case (req_operation)
         OP_MARK:  new_item.in_range = pos_ok && tag_ok;
         OP_CLEAR: new_item.in_range = pos_ok;
         default:  new_item.in_range = 1'b1;
      endcase
   end

   assign full       = cnt_ff == FQ_CNT_W'(FQ_DEPTH);
   assign do_push    = push && !full;
   assign head.valid = cnt_ff != '0;
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_pop     = take && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

### design/btdm_back.sv
// Back end: clears the mask table after reset, then executes queued items against it.
// Depends on btdm_pkg and btdm_ram.
module btdm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  btdm_pkg::head_type         head,
   output logic                       take,
   input  logic                       out_space,
   output btdm_pkg::back_status_type  status,
   output btdm_pkg::result_type       result
);
   import btdm_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_DATA  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   item_type          cur_ff, cur_in;
   logic [MASK_W-1:0] run_ff, run_in;
   logic [LPOS_W-1:0] pos_ff, pos_in;
   logic              ovf_ff, ovf_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [MASK_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [MASK_W-1:0] rd_data;
   logic [MASK_W-1:0] hit;
   logic              pos_fits;

   btdm_ram #(
      .WIDTH (MASK_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos_fits = pos_ff < LPOS_W'(POSITIONS);
   assign hit      = run_ff & rd_data;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      run_in      = run_ff;
      pos_in      = pos_ff;
      ovf_in      = ovf_ff;
      take        = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = {cur_ff.pidx, cur_ff.ch};
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = {head.item.pidx, head.item.ch};
      status      = '0;
      result      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            status.clearing = 1'b1;
            wr_en           = 1'b1;
            wr_addr         = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(TBL_DEPTH - 1)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (head.valid) begin
               cur_in = head.item;
               unique case (head.item.op)
                  OP_MARK: begin
                     take = 1'b1;
                     if (head.item.in_range) begin
                        rd_en    = 1'b1;
                        state_in = ST_DATA;
                     end
                  end
                  OP_CLEAR: begin
                     take = 1'b1;
                     if (head.item.in_range) begin
                        wr_en   = 1'b1;
                        wr_addr = {head.item.pidx, head.item.ch};
                     end
                  end
                  OP_CHAR: begin
                     take = 1'b1;
                     if (pos_fits) begin
                        rd_en    = 1'b1;
                        rd_addr  = {pos_ff[PIDX_W-1:0], head.item.ch};
                        pos_in   = pos_ff + 1'b1;
                        state_in = ST_DATA;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_END: begin
                     if (out_space) begin
                        take = 1'b1;
                        if (pos_fits && !ovf_ff) begin
                           rd_en    = 1'b1;
                           rd_addr  = {pos_ff[PIDX_W-1:0], SPACE_CODE};
                           state_in = ST_DATA;
                        end else begin
                           status.push = 1'b1;
                           run_in      = ALL_ONES;
                           pos_in      = '0;
                           ovf_in      = 1'b0;
                        end
                     end
                  end
               endcase
            end
         end
         ST_DATA: begin
            state_in = ST_ISSUE;
            unique case (cur_ff.op)
               OP_MARK: begin
                  wr_en   = 1'b1;
                  wr_data = rd_data | (MASK_W'(1) << cur_ff.tag);
               end
               OP_CHAR: begin
                  run_in = hit;
               end
               OP_END: begin
                  status.push  = 1'b1;
                  result.found = hit != '0;
                  if (hit[HALF_W-1:0] != '0) begin
                     result.tag_number = {1'b0, top_bit(hit[HALF_W-1:0])};
                  end else if (hit[MASK_W-1:HALF_W] != '0) begin
                     result.tag_number = {1'b1, top_bit(hit[MASK_W-1:HALF_W])};
                  end
                  run_in = ALL_ONES;
                  pos_in = '0;
                  ovf_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         run_ff      <= ALL_ONES;
         pos_ff      <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         run_ff      <= run_in;
         pos_ff      <= pos_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

### tb/sv/bit_parallel_tag_dictionary_match_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tag dictionary match block: loads tags, looks strings up
// and compares every match result with a bit-accurate predictor. Depends on btdm_pkg.
module bit_parallel_tag_dictionary_match_test;
   import btdm_pkg::*;

   localparam int ITEM_TARGET  = 1050;
   localparam int STALL_LIMIT  = 12000;
   localparam int REPORT_LIMIT = 10;
   localparam int WORD_MAX     = 41;
   localparam logic [CHAR_W-1:0] LETTER_A = 7'h41;
   localparam logic [CHAR_W-1:0] LETTER_LOW_A = 7'h61;

   class dictionary_mirror;
      logic [MASK_W-1:0] masks [TBL_DEPTH];
      logic [MASK_W-1:0] running;
      int depth;
      bit overflow;
      result_type awaited_matches[$];
      int mismatches;

      function new();
         foreach (masks[i]) begin
            masks[i] = '0;
         end
         running = ALL_ONES;
         depth = 0;
         overflow = 1'b0;
         mismatches = 0;
      endfunction

      function logic [TAG_W-1:0] highest_tag(logic [MASK_W-1:0] hits);
         logic [TAG_W-1:0] n;
         n = '0;
         if (hits[HALF_W-1:0] != '0) begin
            for (int i = 0; i < HALF_W; i++) begin
               if (hits[i]) n = TAG_W'(i);
            end
         end else begin
            for (int i = HALF_W; i < MASK_W; i++) begin
               if (hits[i]) n = TAG_W'(i);
            end
         end
         return n;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [TAG_W-1:0] tag,
                                 logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
         int entry;
         logic [MASK_W-1:0] hits;
         result_type outcome;
         entry = int'(pos) * ALPHABET + int'(ch);
         case (op)
            OP_MARK: begin
               if (int'(tag) < TAG_SLOTS && int'(pos) < POSITIONS) masks[entry][tag] = 1'b1;
            end
            OP_CLEAR: begin
               if (int'(pos) < POSITIONS) masks[entry] = '0;
            end
            OP_CHAR: begin
               if (depth < POSITIONS) begin
                  running &= masks[depth * ALPHABET + int'(ch)];
                  depth++;
               end else begin
                  overflow = 1'b1;
               end
            end
            default: begin
               hits = '0;
               if (depth < POSITIONS && !overflow) begin
                  hits = running & masks[depth * ALPHABET + int'(SPACE_CODE)];
               end
               outcome.found = (hits != '0);
               outcome.tag_number = outcome.found ? highest_tag(hits) : '0;
               awaited_matches.push_back(outcome);
               running = ALL_ONES;
               depth = 0;
               overflow = 1'b0;
            end
         endcase
      endfunction

      function void flag_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
      endfunction

      function void check_match(logic found, logic [TAG_W-1:0] tag_number);
         result_type want;
         if (awaited_matches.size() == 0) begin
            flag_mismatch($sformatf("found=%0d tag=%0d with no lookup outstanding",
                                    found, tag_number));
            return;
         end
         want = awaited_matches.pop_front();
         if (found !== want.found) begin
            flag_mismatch($sformatf("found expected %0d, actual %0d", want.found, found));
         end
         if (tag_number !== want.tag_number) begin
            flag_mismatch($sformatf("tag_number expected %0d, actual %0d",
                                    want.tag_number, tag_number));
         end
      endfunction

      function int pending();
         return awaited_matches.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [OP_W-1:0]   req_operation = OP_MARK;
   logic [TAG_W-1:0]  req_tag_number_in = '0;
   logic [POS_W-1:0]  req_char_position = '0;
   logic [CHAR_W-1:0] req_character = '0;
   logic              empty;
   logic              pop = 1'b0;
   logic              rsp_found;
   logic [TAG_W-1:0]  rsp_tag_number;

   dictionary_mirror mirror = new();
   int items_sent = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;
   bit calm = 1'b0;
   logic [CHAR_W-1:0] word [WORD_MAX];
   logic [CHAR_W-1:0] tag_text [TAG_SLOTS][POSITIONS];
   int tag_len [TAG_SLOTS];

   bit_parallel_tag_dictionary_match dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_operation    (req_operation),
      .req_tag_number_in(req_tag_number_in),
      .req_char_position(req_char_position),
      .req_character    (req_character),
      .empty            (empty),
      .pop              (pop),
      .rsp_found        (rsp_found),
      .rsp_tag_number   (rsp_tag_number)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Transfers are sampled at the falling edge, where both sides are stable.
   always @(negedge clock) begin
      if (!reset) begin
         if (pop && !empty) mirror.check_match(rsp_found, rsp_tag_number);
         if (push && !full) begin
            mirror.note_request(req_operation, req_tag_number_in, req_char_position,
                                req_character);
         end
         if ((pop && !empty) || (push && !full) || (stimulus_done && mirror.pending() == 0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles == STALL_LIMIT) begin
            $display("bit_parallel_tag_dictionary_match_test: FAIL");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return LETTER_LOW_A + CHAR_W'($urandom_range(0, 3));
      if (roll < 75) return SPACE_CODE;
      return CHAR_W'($urandom_range(0, 127));
   endfunction

   function automatic int pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return 0;
      if (roll < 72) return $urandom_range(1, 5);
      if (roll < 92) return $urandom_range(6, 12);
      return $urandom_range(13, POSITIONS - 1);
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                            input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] ch);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_operation <= op;
      req_tag_number_in <= tag;
      req_char_position <= pos;
      req_character <= ch;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(OP_END, TAG_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
   endtask

   task automatic clear_entry(input int pos, input logic [CHAR_W-1:0] ch);
      send_item(OP_CLEAR, TAG_W'($urandom), POS_W'(pos), ch);
   endtask

   // Marks every character of a tag and then the space terminator after it.
   task automatic mark_tag(input int slot, input int len);
      tag_len[slot] = len;
      for (int i = 0; i < len; i++) begin
         send_item(OP_MARK, TAG_W'(slot), POS_W'(i), tag_text[slot][i]);
      end
      if (len < POSITIONS) send_item(OP_MARK, TAG_W'(slot), POS_W'(len), SPACE_CODE);
   endtask

   task automatic random_tag(input int slot, input int len);
      for (int i = 0; i < len; i++) begin
         tag_text[slot][i] = pick_char();
      end
      mark_tag(slot, len);
   endtask

   task automatic copy_tag(input int slot);
      for (int i = 0; i < tag_len[slot]; i++) begin
         word[i] = tag_text[slot][i];
      end
   endtask

   task automatic look_up(input int len);
      for (int i = 0; i < len; i++) begin
         send_item(OP_CHAR, TAG_W'($urandom), POS_W'($urandom), word[i]);
      end
      send_end();
   endtask

   task automatic drain_matches();
      push <= 1'b0;
      while (mirror.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int gap;
      bit taken;
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do begin
            @(negedge clock);
            taken = !empty;
            @(posedge clock);
         end while (!taken);
      end
   end

   initial begin
      int roll;
      int slot;
      int len;
      int variant;
      foreach (tag_len[i]) begin
         tag_len[i] = -1;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, both halves of the mask, priority, clearing, empty tag.
      send_end();
      tag_text[0][0] = LETTER_A;
      mark_tag(0, 1);
      word[0] = LETTER_A;
      look_up(1);
      tag_text[63][0] = 7'h7f;
      tag_text[63][1] = 7'h00;
      mark_tag(63, 2);
      copy_tag(63);
      look_up(2);
      tag_text[31][0] = LETTER_A;
      mark_tag(31, 1);
      word[0] = LETTER_A;
      look_up(1);
      tag_text[40][0] = LETTER_A;
      mark_tag(40, 1);
      look_up(1);
      clear_entry(1, SPACE_CODE);
      look_up(1);
      mark_tag(5, 0);
      send_end();

      // A full-length tag, then the same string run past the end of the table.
      random_tag(7, POSITIONS - 1);
      copy_tag(7);
      look_up(POSITIONS - 1);
      word[POSITIONS - 1] = pick_char();
      look_up(POSITIONS);
      word[POSITIONS] = pick_char();
      look_up(POSITIONS + 1);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 4) calm = !calm;
         roll = $urandom_range(0, 99);
         if (roll < 22) begin
            random_tag($urandom_range(0, TAG_SLOTS - 1), pick_len());
         end else if (roll < 62) begin
            do slot = $urandom_range(0, TAG_SLOTS - 1); while (tag_len[slot] < 0);
            copy_tag(slot);
            len = tag_len[slot];
            variant = $urandom_range(0, 99);
            if (variant < 60) begin
               look_up(len);
            end else if (variant < 75 && len > 0) begin
               word[$urandom_range(0, len - 1)] = pick_char();
               look_up(len);
            end else if (variant < 88 && len > 0) begin
               look_up(len - 1);
            end else begin
               word[len] = pick_char();
               look_up(len + 1);
            end
         end else if (roll < 72) begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
               word[i] = pick_char();
            end
            look_up(len);
         end else if (roll < 80) begin
            slot = $urandom_range(0, TAG_SLOTS - 1);
            if (tag_len[slot] > 0 && $urandom_range(0, 1) == 1) begin
               len = $urandom_range(0, tag_len[slot]);
               if (len < tag_len[slot]) begin
                  clear_entry(len, tag_text[slot][len]);
               end else if (len < POSITIONS) begin
                  clear_entry(len, SPACE_CODE);
               end
            end else begin
               clear_entry($urandom_range(0, POSITIONS - 1), CHAR_W'($urandom));
            end
         end else if (roll < 90) begin
            send_item(OP_W'($urandom), TAG_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
         end else if (roll < 94) begin
            len = ($urandom_range(0, 1) == 1) ? POSITIONS : $urandom_range(POSITIONS + 1, WORD_MAX);
            for (int i = 0; i < len; i++) begin
               word[i] = pick_char();
            end
            look_up(len);
         end else begin
            drain_matches();
         end
      end

      push <= 1'b0;
      stimulus_done = 1'b1;
      while (mirror.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.pending() == 0) begin
         $display("bit_parallel_tag_dictionary_match_test: PASS");
      end else begin
         $display("bit_parallel_tag_dictionary_match_test: FAIL");
      end
      $finish;
   end

endmodule
